/* rtl/md5_pkg.sv */
// Package with MD5 constants, tables and the controller state type.
package md5_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned CountWidth = 61;

    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hefcdab89;
    localparam logic [31:0] InitC = 32'h98badcfe;
    localparam logic [31:0] InitD = 32'h10325476;
    localparam logic [7:0]  PadByte = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    // Round constants, one per round.
    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
        };
        return k[i];
    endfunction

    // Left rotate amount for a round.
    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s [16];
        s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
              5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
        return s[{i[5:4], i[1:0]}];
    endfunction

    // Message word index used by a round.
    function automatic logic [3:0] word_sel(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
            2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
            default: g = 4'(i[3:0] * 4'd7);
        endcase
        return g;
    endfunction

endpackage

/* rtl/md5_stream_hasher.sv */
// MD5 hasher: byte store in a memory, one round per cycle from a word memory.
// Absorb requests are taken while idle; a block-closing byte adds a copy of the
// byte store into the word memory, the 64 rounds and a fold.
// A finish request writes pad bytes one per cycle, runs one or two compressions,
// then emits four digest words.
// Reset (synchronous, active low) restores the initial chaining words and
// clears the byte count; the byte store needs no clearing.
module md5_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    md5_pkg::t_state r_state, n_state;

    // Byte store and word memory, each with a registered read.
    logic [7:0]  r_bytes [md5_pkg::BlockBytes];
    logic [31:0] r_words [16];
    logic [31:0] r_word_q;

    logic [md5_pkg::CountWidth-1:0] r_count;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_h [4];
    logic [6:0]  r_step;     // load/round/pad step counter
    logic [5:0]  r_pad_ptr;
    logic        r_final;    // this compression ends a finish
    logic        r_len_done; // the length has been placed in the block
    logic [1:0]  r_emit;
    logic [31:0] r_word_acc;

    logic        w_acc;
    logic        w_byte_we;
    logic [5:0]  w_byte_addr;
    logic [7:0]  w_byte_data;
    logic [63:0] w_bits;
    logic [5:0]  w_round;
    logic [31:0] w_f, w_sum, w_rot;
    logic [4:0]  w_sh;

    assign w_acc   = i_valid && o_ready;
    assign w_bits  = {r_count, 3'b000};
    assign w_round = r_step[5:0];

    // Next state. A pad byte that lands in the last slot closes the block
    // at once, so the store goes straight to the copy.
    always_comb begin
        n_state = r_state;
        case (r_state)
            md5_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (r_count[5:0] == 6'd63) n_state = md5_pkg::ST_LOAD;
                    else if (i_command) n_state = md5_pkg::ST_PAD;
                end
            end
            md5_pkg::ST_PAD:
                if (r_pad_ptr == 6'd63) n_state = md5_pkg::ST_LOAD;
            md5_pkg::ST_LOAD:
                if (r_step == 7'd67) n_state = md5_pkg::ST_ROUND;
            md5_pkg::ST_ROUND:
                if (r_step == 7'd63) n_state = md5_pkg::ST_FOLD;
            md5_pkg::ST_FOLD: begin
                if (!r_final) n_state = md5_pkg::ST_IDLE;
                else if (r_len_done) n_state = md5_pkg::ST_EMIT;
                else n_state = md5_pkg::ST_PAD;
            end
            md5_pkg::ST_EMIT:
                if (i_ready && r_emit == 2'd3) n_state = md5_pkg::ST_IDLE;
            default: n_state = md5_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs and byte store write port.
    always_comb begin
        o_ready     = (r_state == md5_pkg::ST_IDLE);
        o_valid     = (r_state == md5_pkg::ST_EMIT);
        w_byte_we   = 1'b0;
        w_byte_addr = r_count[5:0];
        w_byte_data = i_data_byte;
        case (r_state)
            md5_pkg::ST_IDLE: begin
                w_byte_we   = w_acc;
                w_byte_data = i_command ? md5_pkg::PadByte : i_data_byte;
            end
            md5_pkg::ST_PAD: begin
                w_byte_we   = 1'b1;
                w_byte_addr = r_pad_ptr;
                w_byte_data = 8'h00;
                if (r_pad_ptr >= 6'd56 && r_len_done == 1'b0 && r_step[0])
                    w_byte_data = w_bits[8*(r_pad_ptr[2:0]) +: 8];
            end
            default: w_byte_addr = r_step[5:0];
        endcase
    end

    assign o_digest_word = r_h[r_emit];
    assign o_word_index  = r_emit;
    assign o_last_word   = (r_emit == 2'd3);

    // Round datapath.
    always_comb begin
        case (w_round[5:4])
            2'd0: w_f = r_d ^ (r_b & (r_c ^ r_d));
            2'd1: w_f = r_c ^ (r_d & (r_b ^ r_c));
            2'd2: w_f = r_b ^ r_c ^ r_d;
            default: w_f = r_c ^ (r_b | ~r_d);
        endcase
        w_sum = r_a + w_f + r_word_q + md5_pkg::round_const(w_round);
        w_sh  = md5_pkg::rot_amount(w_round);
        w_rot = (w_sum << w_sh) | (w_sum >> (6'd32 - {1'b0, w_sh}));
    end

    // Memories.
    logic [7:0] r_byte_q;
    always_ff @(posedge i_clk) begin
        if (w_byte_we) r_bytes[w_byte_addr] <= w_byte_data;
        r_byte_q <= r_bytes[w_byte_addr];
        if (r_state == md5_pkg::ST_LOAD && r_step >= 7'd1 && r_step[1:0] == 2'd0)
            r_words[4'(r_step[5:2] - 4'd1)] <= {r_byte_q, r_word_acc[31:8]};
        r_word_q <= r_words[(r_state == md5_pkg::ST_ROUND)
                            ? md5_pkg::word_sel(6'(w_round + 6'd1))
                            : md5_pkg::word_sel(6'd0)];
    end

    // Control and chaining registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= md5_pkg::ST_IDLE;
            r_count    <= '0;
            r_h[0]     <= md5_pkg::InitA;
            r_h[1]     <= md5_pkg::InitB;
            r_h[2]     <= md5_pkg::InitC;
            r_h[3]     <= md5_pkg::InitD;
            r_step     <= '0;
            r_pad_ptr  <= '0;
            r_final    <= 1'b0;
            r_len_done <= 1'b0;
            r_emit     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                md5_pkg::ST_IDLE: begin
                    // Pad with the length only if it fits.
                    r_step <= w_acc ? {6'd0, (r_count[5:0] < 6'd56)} : 7'd0;
                    if (w_acc) begin
                        r_final    <= i_command;
                        r_len_done <= 1'b0;
                        r_pad_ptr  <= 6'(r_count[5:0] + 6'd1);
                        if (!i_command) r_count <= r_count + 1'b1;
                    end
                end
                md5_pkg::ST_PAD: begin
                    r_pad_ptr <= r_pad_ptr + 6'd1;
                    if (r_pad_ptr == 6'd63) begin
                        if (r_step[0]) r_len_done <= 1'b1;
                        r_step <= '0;
                    end
                end
                md5_pkg::ST_LOAD: begin
                    // Byte reads are registered, so data arrives the cycle after its address.
                    r_word_acc <= {r_byte_q, r_word_acc[31:8]};
                    r_step <= (r_step == 7'd67) ? 7'd0 : r_step + 7'd1;
                    r_a <= r_h[0];
                    r_b <= r_h[1];
                    r_c <= r_h[2];
                    r_d <= r_h[3];
                end
                md5_pkg::ST_ROUND: begin
                    r_a <= r_d;
                    r_d <= r_c;
                    r_c <= r_b;
                    r_b <= r_b + w_rot;
                    r_step <= r_step + 7'd1;
                end
                md5_pkg::ST_FOLD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_step <= 7'd1;   // second pad pass carries the length
                    r_pad_ptr <= '0;
                    r_emit <= '0;
                end
                md5_pkg::ST_EMIT: begin
                    if (i_ready) begin
                        r_emit <= r_emit + 2'd1;
                        if (r_emit == 2'd3) begin
                            r_h[0]  <= md5_pkg::InitA;
                            r_h[1]  <= md5_pkg::InitB;
                            r_h[2]  <= md5_pkg::InitC;
                            r_h[3]  <= md5_pkg::InitD;
                            r_count <= '0;
                        end
                    end
                end
                default: r_step <= '0;
            endcase
        end
    end

endmodule
